// ===== src/lsl_pkg.sv =====
// Package for the look-ahead stereo limiter: types, fixed-point constants, codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lsl_pkg;

    localparam int SAMPLE_W = 24;
    localparam int STORE_W  = 28;
    localparam int GAIN_W   = 25;
    localparam int LIN_W    = 20;
    localparam int THR_W    = 24;
    localparam int ATK_W    = 10;
    localparam int REL_W    = 14;

    localparam logic signed [GAIN_W-1:0] GAIN_ONE = 25'sd4194304;

    typedef enum logic [2:0] {
        REG_IN_GAIN   = 3'd0,
        REG_THRESHOLD = 3'd1,
        REG_ATTACK    = 3'd2,
        REG_RELEASE   = 3'd3,
        REG_OUT_GAIN  = 3'd4
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRE,
        ST_PEAK,
        ST_DIV,
        ST_GOAL,
        ST_STEPDIV,
        ST_RAMP,
        ST_RELDIV,
        ST_MUL,
        ST_POST,
        ST_OUT
    } t_state;

    // Start and busy between the sequencer and the serial divider.
    typedef struct packed {
        logic start;
        logic busy;
    } t_div_ctl;

endpackage
`default_nettype wire

// ===== src/lsl_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module lsl_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 1024
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_addr,
    input  wire [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== src/lsl_div.sv =====
// Bit-serial restoring divider, unsigned, one quotient bit per cycle.
// Uses lsl_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none
module lsl_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 26
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire [NUM_W-1:0]   i_num,
    input  wire [DEN_W-1:0]   i_den,
    output lsl_pkg::t_div_ctl o_ctl,
    output logic [NUM_W-1:0]  o_quo,
    output logic [DEN_W-1:0]  o_rem
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q;
    logic [DEN_W:0]   r_r;
    logic [DEN_W-1:0] r_d;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;

    assign w_trial = {r_r[DEN_W-1:0], r_q[NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(NUM_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_num;
            r_r <= '0;
            r_d <= i_den;
        end else if (r_cnt != '0) begin
            if (!w_diff[DEN_W]) begin
                r_r <= w_diff;
                r_q <= {r_q[NUM_W-2:0], 1'b1};
            end else begin
                r_r <= w_trial;
                r_q <= {r_q[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_ctl.start = i_start;
    assign o_ctl.busy  = (r_cnt != '0);
    assign o_quo = r_q;
    assign o_rem = r_r[DEN_W-1:0];
endmodule
`default_nettype wire

// ===== src/lookahead_stereo_limiter_core.sv =====
// Top level of the look-ahead stereo limiter: sequencer, gain state, delay rings.
// Depends on lsl_pkg, lsl_ram and lsl_div.
`timescale 1ns / 1ps
`default_nettype none
// One stereo frame is handled at a time. The time from acceptance to result is
// set by how many serial divisions a frame needs: the shared bit-serial divider
// works out the goal gain when the peak is above the threshold, a new attack step
// and a release step; a frame may need none, some or all three. The other steps
// are, in order: pre-gain, ring write, ramp update, gain multiply (28 by 25 bits,
// one channel per cycle), post-gain multiply (32 by 21 bits) and the load of the
// result register. The next frame is taken the cycle after the result register
// is loaded; a stalled result holds the core in its last state. The delay rings
// are single-port RAMs; they hold no reset value, so a clearing pass writes zero
// to all DELAY_DEPTH entries after reset, during which no frame is taken. After
// reset or an attack write the attack length is reduced modulo DELAY_DEPTH by one
// subtraction per cycle, also with input stalled. Config may be written when the
// core is idle.
module lookahead_stereo_limiter_core #(
    parameter int DELAY_DEPTH = 1024
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [23:0] i_left_in,
    input  wire  [23:0] i_right_in,
    input  wire         i_clear_clip,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [23:0] o_left_out,
    output logic [23:0] o_right_out,
    output logic        o_clipped,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [23:0] i_cfg_data
);
    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int GW = lsl_pkg::GAIN_W;
    localparam int SW = lsl_pkg::STORE_W;

    lsl_pkg::t_state r_state, n_state;

    logic [19:0] r_pre, r_post;
    logic [23:0] r_thr;
    logic [9:0]  r_atk;
    logic [9:0]  r_atk_mod;
    logic [13:0] r_rel;

    logic [AW-1:0] r_wp, r_clr_addr;
    logic          r_clearing;
    logic signed [GW-1:0] r_now, r_goal, r_step;
    logic        r_clip;
    logic        r_oclip;
    logic signed [SW-1:0] r_l, r_r;
    logic [26:0] r_peak;
    logic        r_phase;
    logic signed [31:0] r_yl, r_yr;
    logic        r_obuf;
    logic [23:0] r_ol, r_or;
    logic        r_rel_go;

    // Divider
    logic        w_div_start;
    logic [47:0] w_div_num;
    logic [26:0] w_div_den;
    lsl_pkg::t_div_ctl w_div_ctl;
    logic [47:0] w_quo;
    logic [26:0] w_rem;

    lsl_div #(.NUM_W(48), .DEN_W(27)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(w_div_num), .i_den(w_div_den), .o_ctl(w_div_ctl),
        .o_quo(w_quo), .o_rem(w_rem)
    );

    // RAMs
    logic          w_we;
    logic [AW-1:0] w_addr, w_rp;
    logic [SW-1:0] w_ql, w_qr, w_dl, w_dr;

    lsl_ram #(.WIDTH(SW), .DEPTH(DELAY_DEPTH)) u_ram_l (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wdata(w_dl), .o_rdata(w_ql));
    lsl_ram #(.WIDTH(SW), .DEPTH(DELAY_DEPTH)) u_ram_r (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wdata(w_dr), .o_rdata(w_qr));

    // r_atk_mod is reduced below DELAY_DEPTH before any frame is taken
    logic          w_atk_busy;
    logic [AW-1:0] w_atk_mod;
    assign w_atk_busy = (32'(r_atk_mod) >= DELAY_DEPTH);
    assign w_atk_mod  = AW'(r_atk_mod);
    assign w_rp       = (r_wp >= w_atk_mod) ? (r_wp - w_atk_mod)
                                            : (AW'(DELAY_DEPTH) - w_atk_mod + r_wp);

    // Ring: clearing pass, write in ST_PEAK, read address held at w_rp otherwise
    always_comb begin
        w_we   = 1'b0;
        w_addr = w_rp;
        w_dl   = r_l;
        w_dr   = r_r;
        if (r_clearing) begin
            w_we   = 1'b1;
            w_addr = r_clr_addr;
            w_dl   = '0;
            w_dr   = '0;
        end else if (r_state == lsl_pkg::ST_PEAK) begin
            w_we   = 1'b1;
            w_addr = r_wp;
        end
    end

    // Pre-gain, one channel per cycle: round_shr(x*g,16)
    logic signed [23:0] w_pin;
    logic signed [44:0] w_pprod;
    logic signed [SW-1:0] w_pres;
    assign w_pin   = r_phase ? $signed(r_r[23:0]) : $signed(r_l[23:0]);
    assign w_pprod = w_pin * $signed({1'b0, r_pre}) + 45'sd32768;
    assign w_pres  = SW'(w_pprod >>> 16);

    // Magnitudes; the right one is taken from the value being written this cycle
    logic [SW-1:0] w_al, w_apr;
    assign w_al  = r_l[SW-1] ? SW'(-r_l) : r_l;
    assign w_apr = w_pres[SW-1] ? SW'(-w_pres) : w_pres;

    // Step division: |diff| + n - 1 over n
    logic signed [GW+1:0] w_diff;
    logic [13:0]          w_len;
    logic [GW:0]          w_mag;
    logic                 w_neg;
    assign w_diff = r_rel_go ? ((GW+2)'(lsl_pkg::GAIN_ONE) - (GW+2)'(r_now))
                             : ((GW+2)'(r_goal) - (GW+2)'(r_now));
    assign w_len  = r_rel_go ? ((r_rel == '0) ? 14'd1 : r_rel)
                             : ((r_atk == '0) ? 14'd1 : {4'd0, r_atk});
    assign w_neg  = w_diff[GW+1];
    assign w_mag  = w_neg ? (GW+1)'(-w_diff) : (GW+1)'(w_diff);

    logic signed [GW+1:0] w_signed_q;
    assign w_signed_q = w_neg ? -$signed({1'b0, w_quo[GW:0]}) : $signed({1'b0, w_quo[GW:0]});

    always_comb begin
        w_div_start = 1'b0;
        w_div_num   = {24'd0, r_thr} << 22;
        w_div_den   = r_peak;
        case (r_state)
            lsl_pkg::ST_PEAK: w_div_start = (r_peak > 27'(r_thr));
            lsl_pkg::ST_GOAL, lsl_pkg::ST_RAMP: begin
                w_div_num = 48'(w_mag) + 48'(w_len) - 48'd1;
                w_div_den = 27'(w_len);
            end
            default: ;
        endcase
        if (r_state == lsl_pkg::ST_GOAL && r_phase)
            w_div_start = 1'b1;
        if (r_state == lsl_pkg::ST_RAMP && r_phase)
            w_div_start = 1'b1;
    end

    // Ramp arithmetic
    logic signed [GW+1:0] w_sum;
    logic signed [GW-1:0] w_now_sat;
    logic                 w_rel_hit;
    assign w_sum = (GW+2)'(r_now) + (GW+2)'(r_step);
    always_comb begin
        if (w_sum > 27'sd16777215)       w_now_sat = 25'sd16777215;
        else if (w_sum < -27'sd16777216) w_now_sat = -25'sd16777216;
        else                             w_now_sat = w_sum[GW-1:0];
    end
    // gain fell through its goal or to zero: release ramp starts
    assign w_rel_hit = (w_now_sat <= lsl_pkg::GAIN_ONE) &&
                       ((w_now_sat < r_goal) || (w_now_sat <= 0));

    // Output multiplies, one channel per cycle; read data is held at w_rp
    logic signed [SW+GW-1:0] w_m1;
    logic signed [31:0]      w_mi;
    logic signed [52:0]      w_m2;
    assign w_m1 = $signed(r_phase ? w_qr : w_ql) * r_now + (SW+GW)'(2097152);
    assign w_mi = r_phase ? r_yr : r_yl;
    assign w_m2 = w_mi * $signed({1'b0, r_post}) + 53'sd32768;

    function automatic logic [23:0] f_sat(input logic signed [31:0] v);
        if (v > 32'sd8388607)       return 24'h7FFFFF;
        else if (v < -32'sd8388608) return 24'h800000;
        else                        return v[23:0];
    endfunction

    logic w_clip_hit;
    assign w_clip_hit = (r_yl >= 32'sd8388608) || (r_yl <= -32'sd8388608) ||
                        (r_yr >= 32'sd8388608) || (r_yr <= -32'sd8388608);

    logic w_take_in, w_take_out;
    assign w_take_in  = i_valid && !o_stall;
    assign w_take_out = o_valid && !i_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lsl_pkg::ST_IDLE:    if (w_take_in) n_state = lsl_pkg::ST_PRE;
            lsl_pkg::ST_PRE:     if (r_phase) n_state = lsl_pkg::ST_PEAK;
            lsl_pkg::ST_PEAK:    n_state = (r_peak > 27'(r_thr)) ? lsl_pkg::ST_DIV
                                                                 : lsl_pkg::ST_RAMP;
            lsl_pkg::ST_DIV:     if (!w_div_ctl.busy && !w_div_ctl.start)
                                     n_state = lsl_pkg::ST_GOAL;
            lsl_pkg::ST_GOAL:    if (r_phase) n_state = lsl_pkg::ST_STEPDIV;
                                 else if ($signed({1'b0, w_quo[24:0]}) >= 26'(r_goal))
                                     n_state = lsl_pkg::ST_RAMP;
            lsl_pkg::ST_STEPDIV: if (!w_div_ctl.busy && !w_div_ctl.start)
                                     n_state = lsl_pkg::ST_RAMP;
            lsl_pkg::ST_RAMP:    if (r_phase) n_state = lsl_pkg::ST_RELDIV;
                                 else if (!w_rel_hit) n_state = lsl_pkg::ST_MUL;
            lsl_pkg::ST_RELDIV:  if (!w_div_ctl.busy && !w_div_ctl.start)
                                     n_state = lsl_pkg::ST_MUL;
            lsl_pkg::ST_MUL:     if (r_phase) n_state = lsl_pkg::ST_POST;
            lsl_pkg::ST_POST:    if (r_phase) n_state = lsl_pkg::ST_OUT;
            lsl_pkg::ST_OUT:     if (!r_obuf || w_take_out) n_state = lsl_pkg::ST_IDLE;
            default:             n_state = lsl_pkg::ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        o_stall     = r_clearing || w_atk_busy || (r_state != lsl_pkg::ST_IDLE);
        o_cfg_ready = 1'b1;
    end

    assign o_valid     = r_obuf;
    assign o_left_out  = r_ol;
    assign o_right_out = r_or;
    assign o_clipped   = r_oclip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lsl_pkg::ST_IDLE;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_pre      <= 20'd65536;
            r_thr      <= 24'd8388608;
            r_atk      <= 10'd221;
            r_atk_mod  <= 10'd221;
            r_rel      <= 14'd2205;
            r_post     <= 20'd65536;
            r_wp       <= '0;
            r_now      <= lsl_pkg::GAIN_ONE;
            r_goal     <= lsl_pkg::GAIN_ONE;
            r_step     <= '0;
            r_clip     <= 1'b0;
            r_oclip    <= 1'b0;
            r_phase    <= 1'b0;
            r_obuf     <= 1'b0;
            r_rel_go   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(DELAY_DEPTH - 1)) r_clearing <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (lsl_pkg::t_reg_idx'(i_cfg_index))
                    lsl_pkg::REG_IN_GAIN:   r_pre  <= i_cfg_data[19:0];
                    lsl_pkg::REG_THRESHOLD: r_thr  <= i_cfg_data;
                    lsl_pkg::REG_ATTACK:    r_atk  <= i_cfg_data[9:0];
                    lsl_pkg::REG_RELEASE:   r_rel  <= i_cfg_data[13:0];
                    lsl_pkg::REG_OUT_GAIN:  r_post <= i_cfg_data[19:0];
                    default: ;
                endcase
            end
            if (i_cfg_valid && o_cfg_ready &&
                lsl_pkg::t_reg_idx'(i_cfg_index) == lsl_pkg::REG_ATTACK) begin
                r_atk_mod <= i_cfg_data[9:0];
            end else if (w_atk_busy) begin
                r_atk_mod <= r_atk_mod - 10'(DELAY_DEPTH);
            end
            if (w_take_out && r_state != lsl_pkg::ST_OUT) r_obuf <= 1'b0;

            case (r_state)
                lsl_pkg::ST_IDLE: begin
                    r_phase <= 1'b0;
                    if (w_take_in) begin
                        r_l <= SW'($signed(i_left_in));
                        r_r <= SW'($signed(i_right_in));
                        if (i_clear_clip) r_clip <= 1'b0;
                    end
                end
                lsl_pkg::ST_PRE: begin
                    if (r_phase) r_r <= w_pres;
                    else         r_l <= w_pres;
                    r_phase <= !r_phase;
                    if (r_phase) begin
                        r_peak <= 27'((w_al > w_apr) ? w_al : w_apr);
                    end
                end
                lsl_pkg::ST_PEAK: begin
                    r_phase <= 1'b0;
                end
                lsl_pkg::ST_GOAL: begin
                    if (!r_phase) begin
                        if ($signed({1'b0, w_quo[24:0]}) < 26'(r_goal)) begin
                            r_goal  <= w_quo[24:0];
                            r_phase <= 1'b1;
                        end
                    end else begin
                        r_phase <= 1'b0;
                    end
                end
                lsl_pkg::ST_STEPDIV: begin
                    if (!w_div_ctl.busy && !w_div_ctl.start)
                        r_step <= w_signed_q[GW-1:0];
                end
                lsl_pkg::ST_RAMP: begin
                    if (!r_phase) begin
                        if (w_now_sat > lsl_pkg::GAIN_ONE) begin
                            r_now  <= lsl_pkg::GAIN_ONE;
                            r_goal <= lsl_pkg::GAIN_ONE;
                            r_step <= '0;
                        end else begin
                            r_now <= w_now_sat;
                            if (w_rel_hit) begin
                                r_goal   <= lsl_pkg::GAIN_ONE;
                                r_rel_go <= 1'b1;
                                r_phase  <= 1'b1;
                            end
                        end
                    end else begin
                        r_phase <= 1'b0;
                    end
                end
                lsl_pkg::ST_RELDIV: begin
                    if (!w_div_ctl.busy && !w_div_ctl.start) begin
                        r_step   <= w_signed_q[GW-1:0];
                        r_rel_go <= 1'b0;
                    end
                end
                lsl_pkg::ST_MUL: begin
                    if (r_phase) r_yr <= 32'(w_m1 >>> 22);
                    else         r_yl <= 32'(w_m1 >>> 22);
                    r_phase <= !r_phase;
                end
                lsl_pkg::ST_POST: begin
                    if (r_phase) r_yr <= 32'(w_m2 >>> 16);
                    else         r_yl <= 32'(w_m2 >>> 16);
                    r_phase <= !r_phase;
                end
                lsl_pkg::ST_OUT: begin
                    if (!r_obuf || w_take_out) begin
                        r_ol    <= f_sat(r_yl);
                        r_or    <= f_sat(r_yr);
                        r_oclip <= r_clip || w_clip_hit;
                        r_obuf  <= 1'b1;
                        r_wp    <= (r_wp == AW'(DELAY_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                        if (w_clip_hit)
                            r_clip <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire
